// ----- hdl/lpcp_pkg.sv -----
// Shared types, constants and arithmetic helpers for the line pair closest point core.
package lpcp_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH    = 2'd2;

  localparam logic [30:0] PARALLEL_RST = 31'd1074;
  localparam logic [30:0] DEGEN_RST    = 31'd1074;
  localparam logic [16:0] TOUCH_RST    = 17'd1;

  // Outcome codes
  localparam logic [2:0] OUT_INTERSECT = 3'd0;
  localparam logic [2:0] OUT_SKEW      = 3'd1;
  localparam logic [2:0] OUT_PARALLEL  = 3'd2;
  localparam logic [2:0] OUT_DEGEN     = 3'd3;
  localparam logic [2:0] OUT_ZERO      = 3'd4;

  localparam logic [30:0] GAP_MAX   = 31'h7FFF_FFFF;
  localparam logic [33:0] PARAM_LIM = 34'h1_FFFF_FFFF;

  // Iteration counts of the shared arithmetic steps
  localparam int SQRT_STEPS = 32;
  localparam int DIVA_STEPS = 32;
  localparam int DIVB_STEPS = 34;

  typedef struct packed {
    logic signed [31:0] first_point_x;
    logic signed [31:0] first_point_y;
    logic signed [31:0] first_point_z;
    logic signed [31:0] first_dir_x;
    logic signed [31:0] first_dir_y;
    logic signed [31:0] first_dir_z;
    logic signed [31:0] second_point_x;
    logic signed [31:0] second_point_y;
    logic signed [31:0] second_point_z;
    logic signed [31:0] second_dir_x;
    logic signed [31:0] second_dir_y;
    logic signed [31:0] second_dir_z;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] meet_x;
    logic signed [31:0] meet_y;
    logic signed [31:0] meet_z;
    logic [30:0]        gap;
    logic [2:0]         outcome;
  } result_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [67:0] rem;
    logic        hit;
  } div_t;

  // One step of the bitwise integer square root
  function automatic sqrt_t sqrt_step(input logic [63:0] x, input logic [63:0] r,
                                      input int j);
    logic [63:0] b;
    logic [63:0] t;
    sqrt_t o;
    b = 64'd1 << (62 - 2 * j);
    t = r + b;
    if (x >= t) begin
      o.x = x - t;
      o.r = (r >> 1) + b;
    end else begin
      o.x = x;
      o.r = r >> 1;
    end
    return o;
  endfunction

  // One quotient bit of restoring division
  function automatic div_t div_step(input logic [67:0] rem, input logic [33:0] d,
                                    input int k);
    logic [67:0] t;
    div_t o;
    t = 68'(d) << k;
    if (rem >= t) begin
      o.rem = rem - t;
      o.hit = 1'b1;
    end else begin
      o.rem = rem;
      o.hit = 1'b0;
    end
    return o;
  endfunction

  // Left shift that brings the top bit to position 30 or above
  function automatic logic [4:0] lead_shift(input logic [31:0] top);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (top[i]) p = 5'(i);
    end
    if (p >= 5'd30) return 5'd0;
    return 5'd30 - p;
  endfunction

  // Right shift by 30, ties toward plus infinity
  function automatic logic signed [67:0] rshr30(input logic signed [67:0] x);
    return (x + 68'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [67:0] smul(input logic signed [67:0] a,
                                              input logic signed [67:0] b);
    return a * b;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
    if (x > 37'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -37'sd2147483648) return 32'sh8000_0000;
    return 32'(x);
  endfunction

endpackage

// ----- hdl/lpcp_ifs.sv -----
// Valid/ready channel interfaces for line pairs and results.
interface lpcp_pair_if;
  logic            valid;
  logic            ready;
  lpcp_pkg::pair_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lpcp_result_if;
  logic              valid;
  logic              ready;
  lpcp_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/line_pair_closest_point_core.sv -----
// Top level: pipelined closest points between two 3D lines.
// One line pair enters per clock while the pipe advances, and its result leaves at the
// end of the pipe; the pipe holds three 32-stage square root pipelines and two restoring
// dividers (32 and 34 stages) that retire one bit per stage. The whole pipe
// advances together: when the result at the output is not taken, every stage
// holds and the input ready drops. Configuration registers may be written only
// while the pipe holds no item.
module line_pair_closest_point_core (
  input  logic                             clk,
  input  logic                             rst,
  lpcp_pair_if.sink                        pairs,
  lpcp_result_if.source                    closest,
  input  logic                             wr_en,
  input  logic [lpcp_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0]  wr_data
);

  localparam int ST_IN    = 0;
  localparam int ST_SH    = 1;
  localparam int ST_NRM   = 2;
  localparam int ST_SQA   = 3;
  localparam int ST_SUMA  = 4;
  localparam int ST_RTA   = 5;
  localparam int ST_DIVA  = ST_RTA + lpcp_pkg::SQRT_STEPS;
  localparam int ST_QA    = ST_DIVA + 1;
  localparam int ST_UNIT  = ST_QA + lpcp_pkg::DIVA_STEPS;
  localparam int ST_MUL1  = ST_UNIT + 1;
  localparam int ST_ADD1  = ST_MUL1 + 1;
  localparam int ST_MUL2  = ST_ADD1 + 1;
  localparam int ST_ADD2  = ST_MUL2 + 1;
  localparam int ST_SETB  = ST_ADD2 + 1;
  localparam int ST_QB    = ST_SETB + 1;
  localparam int ST_PARM  = ST_QB + lpcp_pkg::DIVB_STEPS;
  localparam int ST_MUL3  = ST_PARM + 1;
  localparam int ST_NEAR  = ST_MUL3 + 1;
  localparam int ST_SEL   = ST_NEAR + 1;
  localparam int ST_SQC   = ST_SEL + 1;
  localparam int ST_SUMC  = ST_SQC + 1;
  localparam int ST_RTC   = ST_SUMC + 1;
  localparam int ST_GAP   = ST_RTC + lpcp_pkg::SQRT_STEPS;
  localparam int ST_OUT   = ST_GAP + 1;
  localparam int NSTG     = ST_OUT + 1;

  typedef struct {
    logic signed [31:0] pa [3];
    logic signed [31:0] pb [3];
    logic signed [32:0] rel [3];
    logic               neg [2][3];
    logic [31:0]        mg [2][3];
    logic [31:0]        top [2];
    logic [4:0]         sh [2];
    logic               zero;
    logic [63:0]        sx [2];
    logic [63:0]        sr [2];
    logic [67:0]        dn [6];
    logic [33:0]        dd [6];
    logic [33:0]        dq [6];
    logic signed [31:0] u [2][3];
    logic signed [67:0] pr [21];
    logic signed [32:0] cr [3];
    logic signed [32:0] aa;
    logic signed [32:0] ab;
    logic signed [32:0] bb;
    logic signed [35:0] ra;
    logic signed [35:0] rb;
    logic signed [33:0] det;
    logic signed [36:0] num [2];
    logic signed [36:0] perp [3];
    logic               degen;
    logic               clamp [2];
    logic               qneg [2];
    logic               par;
    logic signed [34:0] sp [2];
    logic signed [35:0] na [3];
    logic signed [35:0] nb [3];
    logic [36:0]        wm [3];
    logic               big;
    logic signed [36:0] mid [3];
    logic [30:0]        gap;
    logic [2:0]         outcome;
    logic signed [31:0] meet [3];
  } item_t;

  // Configuration registers
  logic [30:0] parallel_lim;
  logic [30:0] degen_lim;
  logic [16:0] touch_lim;

  item_t pipe [NSTG];
  item_t nxt [NSTG];
  logic  vld [NSTG];
  logic  adv;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_lim <= lpcp_pkg::PARALLEL_RST;
      degen_lim    <= lpcp_pkg::DEGEN_RST;
      touch_lim    <= lpcp_pkg::TOUCH_RST;
    end else if (wr_en) begin
      case (wr_index)
        lpcp_pkg::REG_PARALLEL: parallel_lim <= wr_data;
        lpcp_pkg::REG_DEGEN:    degen_lim <= wr_data;
        lpcp_pkg::REG_TOUCH:    touch_lim <= wr_data[16:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the output holds an untaken result
  assign adv          = !vld[NSTG-1] || closest.ready;
  assign pairs.ready  = adv && !rst;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    if (s == ST_IN) begin : g_in
      // Capture the pair, take magnitudes and the offset between points
      always_comb begin
        logic signed [31:0] da [3];
        logic signed [31:0] db [3];
        nxt[s] = pipe[s];
        nxt[s].pa[0] = pairs.data.first_point_x;
        nxt[s].pa[1] = pairs.data.first_point_y;
        nxt[s].pa[2] = pairs.data.first_point_z;
        nxt[s].pb[0] = pairs.data.second_point_x;
        nxt[s].pb[1] = pairs.data.second_point_y;
        nxt[s].pb[2] = pairs.data.second_point_z;
        da[0] = pairs.data.first_dir_x;
        da[1] = pairs.data.first_dir_y;
        da[2] = pairs.data.first_dir_z;
        db[0] = pairs.data.second_dir_x;
        db[1] = pairs.data.second_dir_y;
        db[2] = pairs.data.second_dir_z;
        for (int i = 0; i < 3; i++) begin
          nxt[s].rel[i]   = 33'(nxt[s].pb[i]) - 33'(nxt[s].pa[i]);
          nxt[s].neg[0][i] = da[i][31];
          nxt[s].neg[1][i] = db[i][31];
          nxt[s].mg[0][i]  = da[i][31] ? 32'(-da[i]) : 32'(da[i]);
          nxt[s].mg[1][i]  = db[i][31] ? 32'(-db[i]) : 32'(db[i]);
        end
        for (int l = 0; l < 2; l++) begin
          nxt[s].top[l] = nxt[s].mg[l][0] | nxt[s].mg[l][1] | nxt[s].mg[l][2];
        end
        nxt[s].zero = (nxt[s].top[0] == '0) || (nxt[s].top[1] == '0);
      end
    end else if (s == ST_SH) begin : g_sh
      // Find the normalizing shift of each direction
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int l = 0; l < 2; l++) nxt[s].sh[l] = lpcp_pkg::lead_shift(pipe[s-1].top[l]);
      end
    end else if (s == ST_NRM) begin : g_nrm
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int l = 0; l < 2; l++) begin
          for (int i = 0; i < 3; i++) nxt[s].mg[l][i] = pipe[s-1].mg[l][i] << pipe[s-1].sh[l];
        end
      end
    end else if (s == ST_SQA) begin : g_sqa
      // Square the normalized components
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int l = 0; l < 2; l++) begin
          for (int i = 0; i < 3; i++) begin
            nxt[s].pr[3*l+i] = $signed({4'd0, 64'(pipe[s-1].mg[l][i]) *
                                               64'(pipe[s-1].mg[l][i])});
          end
        end
      end
    end else if (s == ST_SUMA) begin : g_suma
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int l = 0; l < 2; l++) begin
          nxt[s].sx[l] = pipe[s-1].pr[3*l][63:0] + pipe[s-1].pr[3*l+1][63:0] +
                         pipe[s-1].pr[3*l+2][63:0];
          nxt[s].sr[l] = '0;
        end
      end
    end else if (s >= ST_RTA && s < ST_DIVA) begin : g_rta
      // Direction lengths, one root bit per stage
      localparam int J = s - ST_RTA;
      always_comb begin
        lpcp_pkg::sqrt_t st;
        nxt[s] = pipe[s-1];
        for (int l = 0; l < 2; l++) begin
          st = lpcp_pkg::sqrt_step(pipe[s-1].sx[l], pipe[s-1].sr[l], J);
          nxt[s].sx[l] = st.x;
          nxt[s].sr[l] = st.r;
        end
      end
    end else if (s == ST_DIVA) begin : g_diva
      // Set up component / length with rounding
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int l = 0; l < 2; l++) begin
          for (int i = 0; i < 3; i++) begin
            nxt[s].dn[3*l+i] = (68'(pipe[s-1].mg[l][i]) << 30) + 68'(pipe[s-1].sr[l] >> 1);
            nxt[s].dd[3*l+i] = 34'(pipe[s-1].sr[l][31:0]);
            nxt[s].dq[3*l+i] = '0;
          end
        end
      end
    end else if (s >= ST_QA && s < ST_UNIT) begin : g_qa
      localparam int K = lpcp_pkg::DIVA_STEPS - 1 - (s - ST_QA);
      always_comb begin
        lpcp_pkg::div_t dt;
        nxt[s] = pipe[s-1];
        for (int q = 0; q < 6; q++) begin
          dt = lpcp_pkg::div_step(pipe[s-1].dn[q], pipe[s-1].dd[q], K);
          nxt[s].dn[q]    = dt.rem;
          nxt[s].dq[q][K] = dt.hit;
        end
      end
    end else if (s == ST_UNIT) begin : g_unit
      // Restore the signs of the unit components
      always_comb begin
        logic signed [31:0] qv;
        nxt[s] = pipe[s-1];
        for (int l = 0; l < 2; l++) begin
          for (int i = 0; i < 3; i++) begin
            qv = $signed(pipe[s-1].dq[3*l+i][31:0]);
            nxt[s].u[l][i] = pipe[s-1].neg[l][i] ? -qv : qv;
          end
        end
      end
    end else if (s == ST_MUL1) begin : g_mul1
      // Cross and dot product terms
      always_comb begin
        nxt[s] = pipe[s-1];
        nxt[s].pr[0] = lpcp_pkg::smul(pipe[s-1].u[0][1], pipe[s-1].u[1][2]);
        nxt[s].pr[1] = lpcp_pkg::smul(pipe[s-1].u[0][2], pipe[s-1].u[1][1]);
        nxt[s].pr[2] = lpcp_pkg::smul(pipe[s-1].u[0][2], pipe[s-1].u[1][0]);
        nxt[s].pr[3] = lpcp_pkg::smul(pipe[s-1].u[0][0], pipe[s-1].u[1][2]);
        nxt[s].pr[4] = lpcp_pkg::smul(pipe[s-1].u[0][0], pipe[s-1].u[1][1]);
        nxt[s].pr[5] = lpcp_pkg::smul(pipe[s-1].u[0][1], pipe[s-1].u[1][0]);
        for (int i = 0; i < 3; i++) begin
          nxt[s].pr[6+i]  = lpcp_pkg::smul(pipe[s-1].u[0][i], pipe[s-1].u[0][i]);
          nxt[s].pr[9+i]  = lpcp_pkg::smul(pipe[s-1].u[0][i], pipe[s-1].u[1][i]);
          nxt[s].pr[12+i] = lpcp_pkg::smul(pipe[s-1].u[1][i], pipe[s-1].u[1][i]);
          nxt[s].pr[15+i] = lpcp_pkg::smul(pipe[s-1].u[0][i], pipe[s-1].rel[i]);
          nxt[s].pr[18+i] = lpcp_pkg::smul(pipe[s-1].u[1][i], pipe[s-1].rel[i]);
        end
      end
    end else if (s == ST_ADD1) begin : g_add1
      always_comb begin
        nxt[s] = pipe[s-1];
        nxt[s].cr[0] = 33'(lpcp_pkg::rshr30(pipe[s-1].pr[0] - pipe[s-1].pr[1]));
        nxt[s].cr[1] = 33'(lpcp_pkg::rshr30(pipe[s-1].pr[2] - pipe[s-1].pr[3]));
        nxt[s].cr[2] = 33'(lpcp_pkg::rshr30(pipe[s-1].pr[4] - pipe[s-1].pr[5]));
        nxt[s].aa = 33'(lpcp_pkg::rshr30(pipe[s-1].pr[6]) + lpcp_pkg::rshr30(pipe[s-1].pr[7]) +
                        lpcp_pkg::rshr30(pipe[s-1].pr[8]));
        nxt[s].ab = 33'(lpcp_pkg::rshr30(pipe[s-1].pr[9]) + lpcp_pkg::rshr30(pipe[s-1].pr[10]) +
                        lpcp_pkg::rshr30(pipe[s-1].pr[11]));
        nxt[s].bb = 33'(lpcp_pkg::rshr30(pipe[s-1].pr[12]) + lpcp_pkg::rshr30(pipe[s-1].pr[13]) +
                        lpcp_pkg::rshr30(pipe[s-1].pr[14]));
        nxt[s].ra = 36'(lpcp_pkg::rshr30(pipe[s-1].pr[15]) + lpcp_pkg::rshr30(pipe[s-1].pr[16]) +
                        lpcp_pkg::rshr30(pipe[s-1].pr[17]));
        nxt[s].rb = 36'(lpcp_pkg::rshr30(pipe[s-1].pr[18]) + lpcp_pkg::rshr30(pipe[s-1].pr[19]) +
                        lpcp_pkg::rshr30(pipe[s-1].pr[20]));
      end
    end else if (s == ST_MUL2) begin : g_mul2
      // Cross squares, determinant, numerators and projection terms
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int i = 0; i < 3; i++) begin
          nxt[s].pr[i]   = lpcp_pkg::smul(pipe[s-1].cr[i], pipe[s-1].cr[i]);
          nxt[s].pr[9+i] = lpcp_pkg::smul(pipe[s-1].u[0][i], pipe[s-1].ra);
        end
        nxt[s].pr[3] = lpcp_pkg::smul(pipe[s-1].aa, pipe[s-1].bb);
        nxt[s].pr[4] = lpcp_pkg::smul(pipe[s-1].ab, pipe[s-1].ab);
        nxt[s].pr[5] = lpcp_pkg::smul(pipe[s-1].bb, pipe[s-1].ra);
        nxt[s].pr[6] = lpcp_pkg::smul(pipe[s-1].ab, pipe[s-1].rb);
        nxt[s].pr[7] = lpcp_pkg::smul(pipe[s-1].ab, pipe[s-1].ra);
        nxt[s].pr[8] = lpcp_pkg::smul(pipe[s-1].aa, pipe[s-1].rb);
      end
    end else if (s == ST_ADD2) begin : g_add2
      always_comb begin
        nxt[s] = pipe[s-1];
        nxt[s].sx[0] = pipe[s-1].pr[0][63:0] + pipe[s-1].pr[1][63:0] + pipe[s-1].pr[2][63:0];
        nxt[s].sr[0] = '0;
        nxt[s].det = 34'(lpcp_pkg::rshr30(pipe[s-1].pr[3] - pipe[s-1].pr[4]));
        nxt[s].num[0] = 37'(lpcp_pkg::rshr30(pipe[s-1].pr[5]) - lpcp_pkg::rshr30(pipe[s-1].pr[6]));
        nxt[s].num[1] = 37'(lpcp_pkg::rshr30(pipe[s-1].pr[7]) - lpcp_pkg::rshr30(pipe[s-1].pr[8]));
        for (int i = 0; i < 3; i++) begin
          nxt[s].perp[i] = 37'(pipe[s-1].rel[i]) - 37'(lpcp_pkg::rshr30(pipe[s-1].pr[9+i]));
        end
      end
    end else if (s == ST_SETB) begin : g_setb
      // Set up the two line parameter divisions
      always_comb begin
        logic [33:0] dm;
        logic [36:0] nm;
        nxt[s] = pipe[s-1];
        dm = pipe[s-1].det[33] ? 34'(-pipe[s-1].det) : 34'(pipe[s-1].det);
        nxt[s].degen = (pipe[s-1].det == '0) || (dm < 34'(degen_lim));
        for (int q = 0; q < 2; q++) begin
          nm = pipe[s-1].num[q][36] ? 37'(-pipe[s-1].num[q]) : 37'(pipe[s-1].num[q]);
          nxt[s].clamp[q] = 40'(nm) >= (40'(dm) << 3);
          nxt[s].qneg[q]  = pipe[s-1].num[q][36] ^ pipe[s-1].det[33];
          nxt[s].dn[q]    = (68'(nm) << 30) + 68'(dm >> 1);
          nxt[s].dd[q]    = dm;
          nxt[s].dq[q]    = '0;
        end
      end
    end else if (s >= ST_QB && s < ST_PARM) begin : g_qb
      // Parameter quotient bits; the cross norm root runs alongside
      localparam int J = s - ST_QB;
      localparam int K = lpcp_pkg::DIVB_STEPS - 1 - J;
      always_comb begin
        lpcp_pkg::div_t  dt;
        lpcp_pkg::sqrt_t st;
        nxt[s] = pipe[s-1];
        for (int q = 0; q < 2; q++) begin
          dt = lpcp_pkg::div_step(pipe[s-1].dn[q], pipe[s-1].dd[q], K);
          nxt[s].dn[q]    = dt.rem;
          nxt[s].dq[q][K] = dt.hit;
        end
        if (J < lpcp_pkg::SQRT_STEPS) begin
          st = lpcp_pkg::sqrt_step(pipe[s-1].sx[0], pipe[s-1].sr[0], J);
          nxt[s].sx[0] = st.x;
          nxt[s].sr[0] = st.r;
        end
      end
    end else if (s == ST_PARM) begin : g_parm
      // Clamp and sign the parameters, decide parallel
      always_comb begin
        logic [33:0] res;
        nxt[s] = pipe[s-1];
        for (int q = 0; q < 2; q++) begin
          if (pipe[s-1].clamp[q] || pipe[s-1].dq[q] > lpcp_pkg::PARAM_LIM) begin
            res = lpcp_pkg::PARAM_LIM;
          end else begin
            res = pipe[s-1].dq[q];
          end
          nxt[s].sp[q] = pipe[s-1].qneg[q] ? -$signed({1'b0, res}) : $signed({1'b0, res});
        end
        nxt[s].par = pipe[s-1].sr[0] < 64'(parallel_lim);
      end
    end else if (s == ST_MUL3) begin : g_mul3
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int i = 0; i < 3; i++) begin
          nxt[s].pr[i]   = lpcp_pkg::smul(pipe[s-1].u[0][i], pipe[s-1].sp[0]);
          nxt[s].pr[3+i] = lpcp_pkg::smul(pipe[s-1].u[1][i], pipe[s-1].sp[1]);
        end
      end
    end else if (s == ST_NEAR) begin : g_near
      // Closest point on each line
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int i = 0; i < 3; i++) begin
          nxt[s].na[i] = 36'(pipe[s-1].pa[i]) + 36'(lpcp_pkg::rshr30(pipe[s-1].pr[i]));
          nxt[s].nb[i] = 36'(pipe[s-1].pb[i]) + 36'(lpcp_pkg::rshr30(pipe[s-1].pr[3+i]));
        end
      end
    end else if (s == ST_SEL) begin : g_sel
      // Pick the vector whose length is the gap, and the case
      always_comb begin
        logic signed [36:0] w;
        nxt[s] = pipe[s-1];
        if (pipe[s-1].zero) begin
          nxt[s].outcome = lpcp_pkg::OUT_ZERO;
        end else if (pipe[s-1].par) begin
          nxt[s].outcome = lpcp_pkg::OUT_PARALLEL;
        end else if (pipe[s-1].degen) begin
          nxt[s].outcome = lpcp_pkg::OUT_DEGEN;
        end else begin
          nxt[s].outcome = lpcp_pkg::OUT_SKEW;
        end
        for (int i = 0; i < 3; i++) begin
          case (nxt[s].outcome)
            lpcp_pkg::OUT_PARALLEL: w = pipe[s-1].perp[i];
            lpcp_pkg::OUT_SKEW:     w = 37'(pipe[s-1].nb[i]) - 37'(pipe[s-1].na[i]);
            default:                w = '0;
          endcase
          nxt[s].wm[i] = w[36] ? 37'(-w) : 37'(w);
        end
      end
    end else if (s == ST_SQC) begin : g_sqc
      always_comb begin
        nxt[s] = pipe[s-1];
        nxt[s].big = 1'b0;
        for (int i = 0; i < 3; i++) begin
          if (pipe[s-1].wm[i][36:31] != '0) nxt[s].big = 1'b1;
          nxt[s].pr[i] = $signed({4'd0, 64'(pipe[s-1].wm[i][30:0]) *
                                         64'(pipe[s-1].wm[i][30:0])});
        end
      end
    end else if (s == ST_SUMC) begin : g_sumc
      always_comb begin
        nxt[s] = pipe[s-1];
        nxt[s].sx[0] = pipe[s-1].pr[0][63:0] + pipe[s-1].pr[1][63:0] + pipe[s-1].pr[2][63:0];
        nxt[s].sr[0] = '0;
      end
    end else if (s >= ST_RTC && s < ST_GAP) begin : g_rtc
      // Gap length, one root bit per stage
      localparam int J = s - ST_RTC;
      always_comb begin
        lpcp_pkg::sqrt_t st;
        nxt[s] = pipe[s-1];
        st = lpcp_pkg::sqrt_step(pipe[s-1].sx[0], pipe[s-1].sr[0], J);
        nxt[s].sx[0] = st.x;
        nxt[s].sr[0] = st.r;
      end
    end else if (s == ST_GAP) begin : g_gap
      // Saturate the gap and split touching lines from skew ones
      always_comb begin
        nxt[s] = pipe[s-1];
        if (pipe[s-1].big || pipe[s-1].sr[0] > 64'(lpcp_pkg::GAP_MAX)) begin
          nxt[s].gap = lpcp_pkg::GAP_MAX;
        end else begin
          nxt[s].gap = pipe[s-1].sr[0][30:0];
        end
        if (pipe[s-1].outcome == lpcp_pkg::OUT_SKEW && nxt[s].gap < 31'(touch_lim)) begin
          nxt[s].outcome = lpcp_pkg::OUT_INTERSECT;
        end
        for (int i = 0; i < 3; i++) begin
          nxt[s].mid[i] = (37'(pipe[s-1].na[i]) + 37'(pipe[s-1].nb[i]) + 37'sd1) >>> 1;
        end
      end
    end else begin : g_out
      // Select and saturate the meeting point
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int i = 0; i < 3; i++) begin
          case (pipe[s-1].outcome)
            lpcp_pkg::OUT_INTERSECT: nxt[s].meet[i] = lpcp_pkg::sat32(37'(pipe[s-1].na[i]));
            lpcp_pkg::OUT_SKEW:      nxt[s].meet[i] = lpcp_pkg::sat32(pipe[s-1].mid[i]);
            default:                 nxt[s].meet[i] = pipe[s-1].pa[i];
          endcase
        end
      end
    end
  end

  // Advance data and valid bits together
  always_ff @(posedge clk) begin
    if (adv) pipe <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSTG; s++) vld[s] <= 1'b0;
    end else if (adv) begin
      vld[0] <= pairs.valid && pairs.ready;
      for (int s = 1; s < NSTG; s++) vld[s] <= vld[s-1];
    end
  end

  assign closest.valid        = vld[NSTG-1];
  assign closest.data.meet_x  = pipe[NSTG-1].meet[0];
  assign closest.data.meet_y  = pipe[NSTG-1].meet[1];
  assign closest.data.meet_z  = pipe[NSTG-1].meet[2];
  assign closest.data.gap     = pipe[NSTG-1].gap;
  assign closest.data.outcome = pipe[NSTG-1].outcome;

  a_reset_empty: assert property (@(posedge clk) rst |=> !closest.valid)
    else $error("result valid right after reset");

  a_take_item: assert property (@(posedge clk) disable iff (rst)
    pairs.valid && pairs.ready |=> vld[0])
    else $error("accepted pair not captured in first stage");

  a_zero_gap: assert property (@(posedge clk) disable iff (rst)
    closest.valid && (closest.data.outcome == lpcp_pkg::OUT_ZERO ||
                      closest.data.outcome == lpcp_pkg::OUT_DEGEN)
    |-> closest.data.gap == '0)
    else $error("nonzero gap on zero direction or degenerate result");

  a_touch_gap: assert property (@(posedge clk) disable iff (rst)
    closest.valid && closest.data.outcome == lpcp_pkg::OUT_INTERSECT
    |-> closest.data.gap < 31'(touch_lim))
    else $error("intersection reported with gap above touch limit");

endmodule

// ----- tb/line_pair_closest_point_checker.sv -----
// Checker for the line pair core: predicts each result and compares it on transfer.
`timescale 1ns / 100ps

module line_pair_closest_point_checker (
  input  logic                           clk,
  input  logic                           rst,
  lpcp_pair_if                           pairs,
  lpcp_result_if                         closest,
  input  logic                           wr_en,
  input  logic [lpcp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0] wr_data,
  output int                             mismatches,
  output int                             outstanding
);

  typedef logic signed [95:0] wide_t;

  logic [30:0]       par_lim;
  logic [30:0]       deg_lim;
  logic [16:0]       touch_lim;
  lpcp_pkg::result_t expected_results[$];

  function automatic wide_t mag(input wide_t x);
    return x < 0 ? -x : x;
  endfunction

  // Floor of x / 2^k after adding half, so ties go up
  function automatic wide_t round_shift(input wide_t x, input int k);
    return (x + (wide_t'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic wide_t root64(input wide_t xin);
    logic [63:0] x, r, b;
    x = xin[63:0];
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return wide_t'(r);
  endfunction

  function automatic wide_t sat_word(input wide_t x);
    if (x > 96'sh7FFF_FFFF) return 96'sh7FFF_FFFF;
    if (x < -96'sh8000_0000) return -96'sh8000_0000;
    return x;
  endfunction

  function automatic wide_t length_sat(input wide_t w[3]);
    wide_t sum, r;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (mag(w[i]) >= 96'sh8000_0000) return wide_t'(lpcp_pkg::GAP_MAX);
      sum = sum + mag(w[i]) * mag(w[i]);
    end
    r = root64(sum);
    return r > wide_t'(lpcp_pkg::GAP_MAX) ? wide_t'(lpcp_pkg::GAP_MAX) : r;
  endfunction

  // Scale a direction to unit length in Q2.30; zero vector gives 0
  function automatic bit unit_dir(input wide_t raw[3], output wide_t u[3]);
    wide_t m[3], top, sum, len, q;
    int sh;
    top = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(raw[i]);
      if (m[i] > top) top = m[i];
      u[i] = 0;
    end
    if (top == 0) return 1'b0;
    while (top < 96'sh4000_0000) begin
      top = top <<< 1;
      sh++;
    end
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] <<< sh;
      sum = sum + m[i] * m[i];
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] <<< 30) + len / 2) / len;
      u[i] = raw[i] < 0 ? -q : q;
    end
    return 1'b1;
  endfunction

  function automatic wide_t dot(input wide_t x[3], input wide_t y[3]);
    return round_shift(x[0] * y[0], 30) + round_shift(x[1] * y[1], 30) +
           round_shift(x[2] * y[2], 30);
  endfunction

  // Q16.16 over Q2.30, rounded half away from zero and clamped
  function automatic wide_t line_param(input wide_t num, input wide_t den);
    wide_t nm, dm, q, r, res;
    nm = mag(num);
    dm = mag(den);
    q = nm / dm;
    r = nm % dm;
    if (q >= 8) begin
      res = wide_t'(lpcp_pkg::PARAM_LIM);
    end else begin
      res = (q <<< 30) + ((r <<< 30) + dm / 2) / dm;
      if (res > wide_t'(lpcp_pkg::PARAM_LIM)) res = wide_t'(lpcp_pkg::PARAM_LIM);
    end
    return ((num < 0) != (den < 0)) ? -res : res;
  endfunction

  function automatic lpcp_pkg::result_t closest_of(input lpcp_pkg::pair_t p);
    wide_t pa[3], da[3], pb[3], db[3], ua[3], ub[3], rel[3], meet[3];
    wide_t cr[3], perp[3], na[3], nb[3], df[3];
    wide_t gap, csum, along, aa, ab, bb, ra, rb, det, sa, tb;
    logic [2:0] code;
    bit oka, okb;
    lpcp_pkg::result_t res;
    pa = '{p.first_point_x, p.first_point_y, p.first_point_z};
    da = '{p.first_dir_x, p.first_dir_y, p.first_dir_z};
    pb = '{p.second_point_x, p.second_point_y, p.second_point_z};
    db = '{p.second_dir_x, p.second_dir_y, p.second_dir_z};
    gap = 0;
    for (int i = 0; i < 3; i++) begin
      meet[i] = pa[i];
      rel[i] = pb[i] - pa[i];
    end
    oka = unit_dir(da, ua);
    okb = unit_dir(db, ub);
    if (!oka || !okb) begin
      code = lpcp_pkg::OUT_ZERO;
    end else begin
      cr[0] = round_shift(ua[1] * ub[2] - ua[2] * ub[1], 30);
      cr[1] = round_shift(ua[2] * ub[0] - ua[0] * ub[2], 30);
      cr[2] = round_shift(ua[0] * ub[1] - ua[1] * ub[0], 30);
      csum = 0;
      for (int i = 0; i < 3; i++) csum = csum + mag(cr[i]) * mag(cr[i]);
      if (root64(csum) < wide_t'(par_lim)) begin
        along = dot(rel, ua);
        for (int i = 0; i < 3; i++) perp[i] = rel[i] - round_shift(ua[i] * along, 30);
        gap = length_sat(perp);
        code = lpcp_pkg::OUT_PARALLEL;
      end else begin
        aa = dot(ua, ua);
        ab = dot(ua, ub);
        bb = dot(ub, ub);
        ra = dot(ua, rel);
        rb = dot(ub, rel);
        det = round_shift(aa * bb - ab * ab, 30);
        if (det == 0 || mag(det) < wide_t'(deg_lim)) begin
          code = lpcp_pkg::OUT_DEGEN;
        end else begin
          sa = line_param(round_shift(bb * ra, 30) - round_shift(ab * rb, 30), det);
          tb = line_param(round_shift(ab * ra, 30) - round_shift(aa * rb, 30), det);
          for (int i = 0; i < 3; i++) begin
            na[i] = pa[i] + round_shift(ua[i] * sa, 30);
            nb[i] = pb[i] + round_shift(ub[i] * tb, 30);
            df[i] = nb[i] - na[i];
          end
          gap = length_sat(df);
          if (gap < wide_t'(touch_lim)) begin
            code = lpcp_pkg::OUT_INTERSECT;
            for (int i = 0; i < 3; i++) meet[i] = na[i];
          end else begin
            code = lpcp_pkg::OUT_SKEW;
            for (int i = 0; i < 3; i++) meet[i] = round_shift(na[i] + nb[i], 1);
          end
        end
      end
    end
    res.meet_x = 32'(sat_word(meet[0]));
    res.meet_y = 32'(sat_word(meet[1]));
    res.meet_z = 32'(sat_word(meet[2]));
    res.gap = gap[30:0];
    res.outcome = code;
    return res;
  endfunction

  assign outstanding = expected_results.size();

  // Mirror the registers; predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    lpcp_pkg::result_t want, got;
    int errs;
    errs = 0;
    if (rst) begin
      par_lim <= lpcp_pkg::PARALLEL_RST;
      deg_lim <= lpcp_pkg::DEGEN_RST;
      touch_lim <= lpcp_pkg::TOUCH_RST;
      mismatches <= 0;
      expected_results.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          lpcp_pkg::REG_PARALLEL: par_lim <= wr_data;
          lpcp_pkg::REG_DEGEN:    deg_lim <= wr_data;
          lpcp_pkg::REG_TOUCH:    touch_lim <= wr_data[16:0];
          default: ;
        endcase
      end
      if (pairs.valid && pairs.ready) expected_results.push_back(closest_of(pairs.data));
      if (closest.valid && closest.ready) begin
        got = closest.data;
        if (expected_results.size() == 0) begin
          $error("result with no pair pending");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.meet_x !== want.meet_x) begin
            $error("meet_x expected %0d actual %0d", want.meet_x, got.meet_x);
            errs++;
          end
          if (got.meet_y !== want.meet_y) begin
            $error("meet_y expected %0d actual %0d", want.meet_y, got.meet_y);
            errs++;
          end
          if (got.meet_z !== want.meet_z) begin
            $error("meet_z expected %0d actual %0d", want.meet_z, got.meet_z);
            errs++;
          end
          if (got.gap !== want.gap) begin
            $error("gap expected %0d actual %0d", want.gap, got.gap);
            errs++;
          end
          if (got.outcome !== want.outcome) begin
            $error("outcome expected %0d actual %0d", want.outcome, got.outcome);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
  end

endmodule

// ----- tb/line_pair_closest_point_core_test.sv -----
// Top of the line pair core test: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 100ps

module line_pair_closest_point_core_test;

  logic clk;
  logic rst;
  logic wr_en;
  logic [lpcp_pkg::CFG_IDX_W-1:0] wr_index;
  logic [lpcp_pkg::CFG_DATA_W-1:0] wr_data;
  int mismatches;
  int outstanding;
  bit calm;

  lpcp_pair_if pairs();
  lpcp_result_if closest();

  line_pair_closest_point_core uut (
    .clk(clk), .rst(rst), .pairs(pairs), .closest(closest),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  line_pair_closest_point_checker chk (
    .clk(clk), .rst(rst), .pairs(pairs), .closest(closest),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stall the result side at random unless in a calm stretch
  always @(posedge clk) begin
    if (rst) closest.ready <= 1'b0;
    else closest.ready <= calm || ($urandom_range(99) >= 33);
  end

  function automatic logic signed [31:0] pick(input int lo, input int hi);
    return 32'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // Hold the pair until the core takes it, with random idle cycles first
  task automatic send_pair(input lpcp_pkg::pair_t p);
    while (!calm && $urandom_range(99) < 33) begin
      pairs.valid <= 1'b0;
      @(posedge clk);
    end
    pairs.valid <= 1'b1;
    pairs.data <= p;
    @(posedge clk);
    while (!pairs.ready) @(posedge clk);
  endtask

  task automatic drain();
    pairs.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // Present one register write for a cycle; the caller drops the enable
  task automatic write_reg(input logic [lpcp_pkg::CFG_IDX_W-1:0] idx, input logic [30:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [30:0] pl, input logic [30:0] dl,
                            input logic [16:0] tl);
    write_reg(lpcp_pkg::REG_PARALLEL, pl);
    write_reg(lpcp_pkg::REG_DEGEN, dl);
    write_reg(lpcp_pkg::REG_TOUCH, 31'(tl));
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic lpcp_pkg::pair_t noise_pair();
    lpcp_pkg::pair_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return p;
  endfunction

  // Random content, shaped as meeting, skew, parallel or zero-direction geometry
  function automatic lpcp_pkg::pair_t shaped_pair();
    lpcp_pkg::pair_t p;
    int s, t, k, kind;
    p.first_point_x = pick(-(1 << 22), 1 << 22);
    p.first_point_y = pick(-(1 << 22), 1 << 22);
    p.first_point_z = pick(-(1 << 22), 1 << 22);
    p.first_dir_x = pick(-4, 4) <<< 16;
    p.first_dir_y = pick(-4, 4) <<< 16;
    p.first_dir_z = pick(-4, 4) <<< 16;
    p.second_dir_x = pick(-4, 4) <<< 16;
    p.second_dir_y = pick(-4, 4) <<< 16;
    p.second_dir_z = pick(-4, 4) <<< 16;
    s = pick(-20, 20);
    t = pick(-20, 20);
    kind = $urandom_range(9);
    if (kind < 4) begin
      p.second_point_x = p.first_point_x + s * p.first_dir_x - t * p.second_dir_x;
      p.second_point_y = p.first_point_y + s * p.first_dir_y - t * p.second_dir_y;
      p.second_point_z = p.first_point_z + s * p.first_dir_z - t * p.second_dir_z;
    end else begin
      p.second_point_x = p.first_point_x + pick(-(1 << 20), 1 << 20);
      p.second_point_y = p.first_point_y + pick(-(1 << 20), 1 << 20);
      p.second_point_z = p.first_point_z + pick(-(1 << 20), 1 << 20);
    end
    if (kind == 6 || kind == 7) begin
      k = pick(-3, 3);
      p.second_dir_x = k * p.first_dir_x + pick(-1, 1);
      p.second_dir_y = k * p.first_dir_y + pick(-1, 1);
      p.second_dir_z = k * p.first_dir_z;
    end
    if (kind == 8) begin
      p.first_dir_x = pick(-(1 << 30), 1 << 30);
      p.first_dir_y = pick(-(1 << 30), 1 << 30);
      p.first_dir_z = pick(-(1 << 30), 1 << 30);
      p.second_dir_x = p.first_dir_x + pick(-2, 2);
      p.second_dir_y = p.first_dir_y;
      p.second_dir_z = p.first_dir_z + pick(-2, 2);
      p.second_point_x = $urandom;
    end
    if (kind == 9 && $urandom_range(1)) p.second_dir_x = 0;
    if (kind == 9) begin
      p.first_dir_x = 0;
      p.first_dir_y = 0;
      p.first_dir_z = 0;
    end
    return p;
  endfunction

  function automatic lpcp_pkg::pair_t line_pair(input logic signed [31:0] p1[3],
                                                input logic signed [31:0] d1[3],
                                                input logic signed [31:0] p2[3],
                                                input logic signed [31:0] d2[3]);
    return {p1[0], p1[1], p1[2], d1[0], d1[1], d1[2],
            p2[0], p2[1], p2[2], d2[0], d2[1], d2[2]};
  endfunction

  task automatic directed_items();
    localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    send_pair(line_pair('{0, 0, 0}, '{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}));
    send_pair(line_pair('{ONE, 2, 3}, '{ONE, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
    send_pair(line_pair('{0, 0, 0}, '{ONE, 0, 0}, '{0, 0, ONE}, '{0, ONE, 0}));
    send_pair(line_pair('{0, 0, 0}, '{ONE, 0, 0}, '{5 * ONE, -3 * ONE, 0},
                        '{0, ONE, 0}));
    send_pair(line_pair('{0, 0, 0}, '{ONE, ONE, 0}, '{0, 7 * ONE, 0},
                        '{2 * ONE, 2 * ONE, 0}));
    send_pair(line_pair('{MX, MX, MX}, '{MX, MX, MX}, '{MN, MN, MN}, '{MN, MX, 1}));
    send_pair(line_pair('{MN, MN, MN}, '{MN, MN, MN}, '{MX, MX, MX}, '{MN, MN, MN}));
    send_pair(line_pair('{MN, 0, MX}, '{1, 0, 0}, '{MX, MN, 0}, '{0, 1, 0}));
    send_pair(line_pair('{MX, MN, 0}, '{-1, -1, -1}, '{MN, MX, 0}, '{1, -1, 0}));
    send_pair(line_pair('{MX, MX, MX}, '{MX, MX - 1, MX}, '{MN, MN, MN},
                        '{MX, MX, MX}));
    send_pair(line_pair('{0, 0, 0}, '{ONE, 0, 0}, '{MX, MX, MX}, '{ONE, 1, 0}));
    send_pair(line_pair('{-1, -1, -1}, '{MN, 0, 0}, '{1, 1, 1}, '{0, MN, 0}));
    send_pair(line_pair('{ONE, ONE, ONE}, '{0, 0, MX}, '{MN, MX, ONE}, '{0, 0, MN}));
    send_pair(line_pair('{0, 0, 0}, '{ONE, 0, 0}, '{0, 1, 0}, '{0, ONE, 0}));
    send_pair(line_pair('{0, 0, 0}, '{ONE, 2 * ONE, 3 * ONE}, '{0, 0, 0},
                        '{-3 * ONE, 0, ONE}));
  endtask

  initial begin
    logic [30:0] pl[6];
    logic [30:0] dl[6];
    logic [16:0] tl[6];
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = lpcp_pkg::REG_PARALLEL;
    wr_data = '0;
    pairs.valid = 1'b0;
    pairs.data = '0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Reset settings first, then the extremes and a few middle settings
    directed_items();
    drain();
    pl = '{31'd0, 31'h4000_0000, 31'd1, 31'd5_000_000, 31'h2AAA_AAAB, 31'd1074};
    dl = '{31'd0, 31'h4000_0000, 31'h7FFF_FFFF, 31'd70_000, 31'd12345, 31'd1074};
    tl = '{17'd0, 17'd65536, 17'd1, 17'd300, 17'h1FFFF, 17'd1};
    for (int ph = 0; ph < 6; ph++) begin
      set_limits(pl[ph], dl[ph], tl[ph]);
      if (ph == 0) directed_items();
      calm = (ph == 3);
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(99) < 75) send_pair(shaped_pair());
        else send_pair(noise_pair());
        if (ph == 4 && n == 60) begin
          pairs.valid <= 1'b0;
          @(posedge clk);
          while (outstanding != 0) @(posedge clk);
        end
      end
      calm = 1'b0;
      drain();
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Bound the run well past the slowest legal completion
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- line_pair_closest_point_core.f -----
hdl/lpcp_pkg.sv
hdl/lpcp_ifs.sv
hdl/line_pair_closest_point_core.sv
tb/line_pair_closest_point_checker.sv
tb/line_pair_closest_point_core_test.sv
